// File: rtl/core/scan_sector_min_safety_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan sector classifier
// Same-cycle-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SCAN_SECTOR_MIN_SAFETY_CLASSIFIER_ASSERT_SVH
`define SCAN_SECTOR_MIN_SAFETY_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define SSMSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ssmsc assertion failed");
// next-cycle implication, disabled while in reset
`define SSMSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ssmsc assertion failed");
`else
`define SSMSC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SSMSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/ssmsc_pkg.sv
// ----------------------------------------------------------------------------
// ssmsc_pkg
// Shared types and constants of the scan sector minimum classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmsc_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam int START_W     = 19;
	localparam int STEP_W      = 18;
	localparam int MM_W        = 16;
	localparam int PROD_W      = IDX_W + 1 + STEP_W;
	localparam int ANGLE_W     = PROD_W + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = START_W;

	// sample queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// result queue at the output
	localparam int R_DEPTH = 2;
	localparam int R_PTR_W = $clog2(R_DEPTH);
	localparam int R_CNT_W = $clog2(R_DEPTH + 1);

	// sector bounds, Q16 radians
	localparam logic signed [ANGLE_W-1:0] DEG30_Q16 = ANGLE_W'(34315);
	localparam logic signed [ANGLE_W-1:0] DEG90_Q16 = ANGLE_W'(102944);

	localparam logic [MM_W-1:0] NO_READING = '1;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_FRONT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAUTION_FRT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CAUTION_SIDE = 3'd6;

	localparam logic signed [START_W-1:0] START_RST   = START_W'(-205887);
	localparam logic signed [STEP_W-1:0]  STEP_RST    = STEP_W'(1144);
	localparam logic [MM_W-1:0]           VMIN_RST    = MM_W'(0);
	localparam logic [MM_W-1:0]           VMAX_RST    = MM_W'(65535);
	localparam logic [MM_W-1:0]           DANGER_RST  = MM_W'(600);
	localparam logic [MM_W-1:0]           CAUT_F_RST  = MM_W'(1200);
	localparam logic [MM_W-1:0]           CAUT_S_RST  = MM_W'(800);

	typedef enum logic [1:0] {
		CLS_SAFE    = 2'd0,
		CLS_CAUTION = 2'd1,
		CLS_DANGER  = 2'd2
	} class_t;

	typedef struct packed {
		logic signed [START_W-1:0] start_angle_q16;
		logic signed [STEP_W-1:0]  angle_step_q16;
		logic [MM_W-1:0]           valid_min_mm;
		logic [MM_W-1:0]           valid_max_mm;
		logic [MM_W-1:0]           danger_front_mm;
		logic [MM_W-1:0]           caution_front_mm;
		logic [MM_W-1:0]           caution_side_mm;
	} cfg_t;

	// classified sample, front -> back
	typedef struct packed {
		logic [MM_W-1:0] range_mm;
		logic            hit_front;
		logic            hit_left;
		logic            hit_right;
		logic            last;
	} sample_t;

	typedef struct packed {
		class_t          cls;
		logic [MM_W-1:0] front_mm;
		logic [MM_W-1:0] left_mm;
		logic [MM_W-1:0] right_mm;
	} result_t;

	// queue status seen by front and back
	typedef struct packed {
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ssmsc_front.sv
// ----------------------------------------------------------------------------
// ssmsc_front
// Accepts samples, derives the angle and tags each sample with its sectors.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmsc_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ssmsc_pkg::cfg_t              cfg,
	input  wire                          push,
	output logic                         full,
	input  wire [ssmsc_pkg::MM_W-1:0]    distance_mm,
	input  wire                          finite,
	input  wire                          last,
	input  ssmsc_pkg::q_stat_t           q_stat,
	output logic                         q_push,
	output ssmsc_pkg::sample_t           q_data
);

	logic                                   accept;
	logic [ssmsc_pkg::IDX_W-1:0]            idx_q;
	logic                                   valid_s1;
	logic                                   ok_s1;
	logic                                   last_s1;
	logic [ssmsc_pkg::MM_W-1:0]             dist_s1;
	logic signed [ssmsc_pkg::PROD_W-1:0]    prod_s1;
	logic signed [ssmsc_pkg::PROD_W-1:0]    prod;
	logic signed [ssmsc_pkg::ANGLE_W-1:0]   angle;

	// credit: one beat may be in s1, so leave it a slot
	assign full = (q_stat.count == ssmsc_pkg::Q_CNT_W'(ssmsc_pkg::Q_DEPTH)) ||
		(valid_s1 && q_stat.count == ssmsc_pkg::Q_CNT_W'(ssmsc_pkg::Q_DEPTH - 1));
	assign accept = push && !full;

	assign prod = $signed({1'b0, idx_q}) * $signed(cfg.angle_step_q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last) begin
					idx_q <= '0;
				end else if (idx_q != ssmsc_pkg::IDX_W'(ssmsc_pkg::MAX_SAMPLES - 1)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1 <= prod;
			dist_s1 <= distance_mm;
			last_s1 <= last;
			ok_s1   <= finite && (distance_mm >= cfg.valid_min_mm) &&
				(distance_mm <= cfg.valid_max_mm);
		end
	end

	assign angle =
		{{(ssmsc_pkg::ANGLE_W - ssmsc_pkg::START_W){cfg.start_angle_q16[ssmsc_pkg::START_W-1]}},
			cfg.start_angle_q16} +
		{prod_s1[ssmsc_pkg::PROD_W-1], prod_s1};

	always_comb begin
		q_push           = valid_s1;
		q_data.range_mm  = dist_s1;
		q_data.last      = last_s1;
		q_data.hit_front = ok_s1 && (angle >= -ssmsc_pkg::DEG30_Q16) &&
			(angle <= ssmsc_pkg::DEG30_Q16);
		q_data.hit_left  = ok_s1 && (angle >= ssmsc_pkg::DEG30_Q16) &&
			(angle <= ssmsc_pkg::DEG90_Q16);
		q_data.hit_right = ok_s1 && (angle >= -ssmsc_pkg::DEG90_Q16) &&
			(angle <= -ssmsc_pkg::DEG30_Q16);
	end

endmodule

`default_nettype wire

// File: rtl/core/ssmsc_sample_q.sv
// ----------------------------------------------------------------------------
// ssmsc_sample_q
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmsc_sample_q (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  ssmsc_pkg::sample_t   wr_data,
	input  wire                  rd_en,
	output ssmsc_pkg::sample_t   rd_data,
	output ssmsc_pkg::q_stat_t   stat
);

	ssmsc_pkg::sample_t                 mem_q [ssmsc_pkg::Q_DEPTH];
	logic [ssmsc_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [ssmsc_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [ssmsc_pkg::Q_CNT_W-1:0]      count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);

endmodule

`default_nettype wire

// File: rtl/core/ssmsc_back.sv
// ----------------------------------------------------------------------------
// ssmsc_back
// Running sector minima, classification on the last beat, result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmsc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  ssmsc_pkg::cfg_t      cfg,
	input  ssmsc_pkg::q_stat_t   q_stat,
	input  ssmsc_pkg::sample_t   q_data,
	output logic                 q_pop,
	input  wire                  pop,
	output logic                 empty,
	output ssmsc_pkg::result_t   result
);

	logic [ssmsc_pkg::MM_W-1:0]     front_q;
	logic [ssmsc_pkg::MM_W-1:0]     left_q;
	logic [ssmsc_pkg::MM_W-1:0]     right_q;
	logic [ssmsc_pkg::MM_W-1:0]     front_nx;
	logic [ssmsc_pkg::MM_W-1:0]     left_nx;
	logic [ssmsc_pkg::MM_W-1:0]     right_nx;
	ssmsc_pkg::result_t             res_nx;
	ssmsc_pkg::result_t             res_mem_q [ssmsc_pkg::R_DEPTH];
	logic [ssmsc_pkg::R_PTR_W-1:0]  res_wr_q;
	logic [ssmsc_pkg::R_PTR_W-1:0]  res_rd_q;
	logic [ssmsc_pkg::R_CNT_W-1:0]  res_cnt_q;
	logic                           res_push;
	logic                           res_pop;

	// a last beat waits for a free result slot
	assign q_pop = !q_stat.empty &&
		(!q_data.last || res_cnt_q != ssmsc_pkg::R_CNT_W'(ssmsc_pkg::R_DEPTH));
	assign res_push = q_pop && q_data.last;
	assign res_pop  = pop && !empty;

	assign front_nx = (q_data.hit_front && q_data.range_mm < front_q) ?
		q_data.range_mm : front_q;
	assign left_nx  = (q_data.hit_left  && q_data.range_mm < left_q) ?
		q_data.range_mm : left_q;
	assign right_nx = (q_data.hit_right && q_data.range_mm < right_q) ?
		q_data.range_mm : right_q;

	always_comb begin
		res_nx.front_mm = front_nx;
		res_nx.left_mm  = left_nx;
		res_nx.right_mm = right_nx;
		if (front_nx < cfg.danger_front_mm) begin
			res_nx.cls = ssmsc_pkg::CLS_DANGER;
		end else if (front_nx < cfg.caution_front_mm || left_nx < cfg.caution_side_mm ||
				right_nx < cfg.caution_side_mm) begin
			res_nx.cls = ssmsc_pkg::CLS_CAUTION;
		end else begin
			res_nx.cls = ssmsc_pkg::CLS_SAFE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= ssmsc_pkg::NO_READING;
			left_q    <= ssmsc_pkg::NO_READING;
			right_q   <= ssmsc_pkg::NO_READING;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (q_pop) begin
				if (q_data.last) begin
					front_q <= ssmsc_pkg::NO_READING;
					left_q  <= ssmsc_pkg::NO_READING;
					right_q <= ssmsc_pkg::NO_READING;
				end else begin
					front_q <= front_nx;
					left_q  <= left_nx;
					right_q <= right_nx;
				end
			end
			if (res_push) begin
				res_wr_q <= res_wr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_q <= res_rd_q + 1'b1;
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 1'b1;
				2'b01:   res_cnt_q <= res_cnt_q - 1'b1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[res_wr_q] <= res_nx;
		end
	end

	assign empty  = (res_cnt_q == '0);
	assign result = res_mem_q[res_rd_q];

endmodule

`default_nettype wire

// File: rtl/core/scan_sector_min_safety_classifier.sv
// ----------------------------------------------------------------------------
// scan_sector_min_safety_classifier
// Per-scan minimum range in front/left/right sectors and a safety class.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  sample in | push / full            | distance_mm, finite, last
//  result    | empty / pop            | safety_class, front/left/right_min_mm
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One sample beat per cycle sustained while full stays low; a sample reaches the back
//  end through the multiply stage, then the queue. A result is poppable once its last
//  beat has passed the angle multiply, the sample queue and the result queue. Reset is
//  asynchronous and needs no clearing pass. full rises when the sample queue has no
//  slot left for a new beat beside one already in the multiply stage; the back end
//  stalls a last beat while both result slots are held.
//  cfg_ready is always high; writes take effect on the next edge.
//
`default_nettype none

`include "scan_sector_min_safety_classifier_assert.svh"

module scan_sector_min_safety_classifier (
	input  wire                                clk,
	input  wire                                arst_n,
	// sample input
	input  wire                                push,
	output logic                               full,
	input  wire [15:0]                         distance_mm,
	input  wire                                finite,
	input  wire                                last,
	// result output
	output logic                               empty,
	input  wire                                pop,
	output logic [1:0]                         safety_class,
	output logic [15:0]                        front_min_mm,
	output logic [15:0]                        left_min_mm,
	output logic [15:0]                        right_min_mm,
	// register writes
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [ssmsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [ssmsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	ssmsc_pkg::cfg_t     cfg_q;
	ssmsc_pkg::q_stat_t  q_stat;
	ssmsc_pkg::sample_t  q_wr_data;
	ssmsc_pkg::sample_t  q_rd_data;
	ssmsc_pkg::result_t  result;
	logic                q_push;
	logic                q_pop;
	logic                cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// register file; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_angle_q16  <= ssmsc_pkg::START_RST;
			cfg_q.angle_step_q16   <= ssmsc_pkg::STEP_RST;
			cfg_q.valid_min_mm     <= ssmsc_pkg::VMIN_RST;
			cfg_q.valid_max_mm     <= ssmsc_pkg::VMAX_RST;
			cfg_q.danger_front_mm  <= ssmsc_pkg::DANGER_RST;
			cfg_q.caution_front_mm <= ssmsc_pkg::CAUT_F_RST;
			cfg_q.caution_side_mm  <= ssmsc_pkg::CAUT_S_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				ssmsc_pkg::REG_START_ANGLE:  cfg_q.start_angle_q16  <= cfg_data;
				ssmsc_pkg::REG_ANGLE_STEP:
					cfg_q.angle_step_q16 <= cfg_data[ssmsc_pkg::STEP_W-1:0];
				ssmsc_pkg::REG_VALID_MIN:
					cfg_q.valid_min_mm <= cfg_data[ssmsc_pkg::MM_W-1:0];
				ssmsc_pkg::REG_VALID_MAX:
					cfg_q.valid_max_mm <= cfg_data[ssmsc_pkg::MM_W-1:0];
				ssmsc_pkg::REG_DANGER_FRONT:
					cfg_q.danger_front_mm <= cfg_data[ssmsc_pkg::MM_W-1:0];
				ssmsc_pkg::REG_CAUTION_FRT:
					cfg_q.caution_front_mm <= cfg_data[ssmsc_pkg::MM_W-1:0];
				ssmsc_pkg::REG_CAUTION_SIDE:
					cfg_q.caution_side_mm <= cfg_data[ssmsc_pkg::MM_W-1:0];
				default: ;
			endcase
		end
	end

	// front: take beat, multiply index by step, tag sectors
	ssmsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.distance_mm (distance_mm),
		.finite      (finite),
		.last        (last),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	ssmsc_sample_q u_sample_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.stat    (q_stat)
	);

	// back: min update, class on last beat, result queue
	ssmsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.q_data (q_rd_data),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	assign safety_class = result.cls;
	assign front_min_mm = result.front_mm;
	assign left_min_mm  = result.left_mm;
	assign right_min_mm = result.right_mm;

	// credit scheme must never overrun the sample queue
	`SSMSC_ASSERT_NOW(a_q_no_overflow, clk, arst_n, q_push && !q_pop,
		q_stat.count != ssmsc_pkg::Q_CNT_W'(ssmsc_pkg::Q_DEPTH))
	// a waiting danger result agrees with the front threshold
	`SSMSC_ASSERT_NOW(a_danger_consistent, clk, arst_n,
		!empty && safety_class == ssmsc_pkg::CLS_DANGER,
		front_min_mm < cfg_q.danger_front_mm)
	// a waiting safe result has every minimum at or above its threshold
	`SSMSC_ASSERT_NOW(a_safe_consistent, clk, arst_n,
		!empty && safety_class == ssmsc_pkg::CLS_SAFE,
		front_min_mm >= cfg_q.caution_front_mm && left_min_mm >= cfg_q.caution_side_mm &&
		right_min_mm >= cfg_q.caution_side_mm)
	// back end only drains what is there
	`SSMSC_ASSERT_NOW(a_q_no_underflow, clk, arst_n, q_pop, !q_stat.empty)

endmodule

`default_nettype wire
